FILE: rtl/sha256_pkg.sv
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;

  typedef struct packed {
    logic       command;
    logic [7:0] message_byte;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_part0;
    logic [63:0] digest_part1;
    logic [63:0] digest_part2;
    logic [63:0] digest_part3;
  } out_word_t;

  typedef enum logic [1:0] {
    BYTE_MSG  = 2'd0,
    BYTE_PAD  = 2'd1,
    BYTE_ZERO = 2'd2,
    BYTE_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic       load_byte;
    byte_sel_t  byte_sel;
    logic [2:0] len_idx;
    logic       round_start;
    logic       round_step;
    logic       round_last;
    logic       fold;
    logic       restart;
    logic       count_byte;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill_count;
  } dp_stat_t;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

FILE: rtl/sha256_datapath.sv
module sha256_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sha256_pkg::dp_cmd_t  cmd,
  input  logic [7:0]           message_byte,
  output sha256_pkg::dp_stat_t stat,
  output sha256_pkg::out_word_t digest
);
  import sha256_pkg::*;

  logic [5:0]  fill_count;
  logic [63:0] message_length;
  logic [31:0] hash [8];
  logic [31:0] wv [8];
  logic [31:0] win [16];
  logic [5:0]  round;
  logic [63:0] bits;
  logic [7:0]  byte_in;
  logic [31:0] w_t, w_new, t1, t2, s0, s1, e, a;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  assign bits = {message_length[60:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      BYTE_MSG:  byte_in = message_byte;
      BYTE_PAD:  byte_in = PadByte;
      BYTE_ZERO: byte_in = 8'h00;
      BYTE_LEN:  byte_in = bits[8*(7-cmd.len_idx) +: 8];
      default:   byte_in = 8'h00;
    endcase
  end

  always_comb begin
    s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    w_new = s1 + win[9] + s0 + win[0];
    w_t = (round < 6'd16) ? win[0] : w_new;
    e = wv[4];
    a = wv[0];
    t1 = wv[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & wv[5]) ^ (~e & wv[6])) + RoundK[round] + w_t;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & wv[1]) ^ (a & wv[2]) ^ (wv[1] & wv[2]));
  end

  // load bytes big-endian into the window; it shifts; win[0] feeds w_t in rounds 0-15
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      win[fill_count[5:2]][{~fill_count[1:0], 3'b000} +: 8] <= byte_in;
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w_t;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      for (int i = 0; i < 8; i++) wv[i] <= hash[i];
    end else if (cmd.round_step) begin
      wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
      wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) hash[i] <= InitHash[i];
      fill_count     <= '0;
      message_length <= '0;
      round          <= '0;
    end else begin
      if (cmd.load_byte) fill_count <= fill_count + 6'd1;
      if (cmd.count_byte) message_length <= message_length + 64'd1;
      if (cmd.round_start) round <= '0;
      else if (cmd.round_step) round <= round + 6'd1;
      if (cmd.fold)
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wv[i];
    end
  end

  assign stat.fill_count = fill_count;
  assign digest = '{digest_part0: {hash[0], hash[1]}, digest_part1: {hash[2], hash[3]},
                    digest_part2: {hash[4], hash[5]}, digest_part3: {hash[6], hash[7]}};

endmodule

FILE: rtl/sha256_control.sv
module sha256_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  sha256_pkg::dp_stat_t stat,
  output sha256_pkg::dp_cmd_t  cmd
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    IDLE, START, ROUND, FOLD, PAD, OUTPUT
  } state_t;

  state_t     state, state_next;
  logic [5:0] rcount, rcount_next;
  logic       finishing, finishing_next;
  logic       final_blk, final_blk_next;
  logic       out_valid_next;
  logic       accept;

  assign in_stall = (state != IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    rcount_next    = rcount;
    finishing_next = finishing;
    final_blk_next = final_blk;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.byte_sel   = BYTE_MSG;
    cmd.len_idx    = stat.fill_count[2:0];
    case (state)
      IDLE: begin
        if (accept) begin
          if (!in_command) begin
            cmd.load_byte  = 1'b1;
            cmd.count_byte = 1'b1;
            finishing_next = 1'b0;
            if (stat.fill_count == 6'(BlockBytes - 1)) state_next = START;
          end else begin
            cmd.load_byte  = 1'b1;
            cmd.byte_sel   = BYTE_PAD;
            finishing_next = 1'b1;
            final_blk_next = 1'b0;
            state_next = (stat.fill_count == 6'(BlockBytes - 1)) ? START : PAD;
          end
        end
      end
      PAD: begin
        cmd.load_byte = 1'b1;
        // length goes only in the final block: this one if the 0x80 left room for it, else the extra block
        if (stat.fill_count >= 6'd56 && final_blk)
          cmd.byte_sel = BYTE_LEN;
        else
          cmd.byte_sel = BYTE_ZERO;
        if (stat.fill_count == 6'(BlockBytes - 1)) state_next = START;
      end
      START: begin
        cmd.round_start = 1'b1;
        rcount_next = '0;
        state_next = ROUND;
      end
      ROUND: begin
        cmd.round_step = 1'b1;
        rcount_next = rcount + 6'd1;
        if (rcount == 6'(Rounds - 1)) state_next = FOLD;
      end
      FOLD: begin
        cmd.fold = 1'b1;
        if (!finishing) state_next = IDLE;
        else if (final_blk) begin
          state_next = OUTPUT;
        end else begin
          state_next = PAD;
        end
      end
      OUTPUT: begin
        out_valid_next = 1'b1;
        cmd.restart = 1'b1;
        state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rcount    <= '0;
      finishing <= 1'b0;
      final_blk <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rcount    <= rcount_next;
      finishing <= finishing_next;
      out_valid <= out_valid_next;
      if (accept && in_command) begin
        final_blk <= (stat.fill_count < 6'd56);
      end else if (state == FOLD && finishing && !final_blk) begin
        final_blk <= 1'b1;
      end else begin
        final_blk <= final_blk_next;
      end
    end
  end

endmodule

FILE: rtl/sha256_stream_hasher.sv
// channel | dir | payload      | handshake
// in      | in  | in_word_t    | in_valid / in_stall
// out     | out | out_word_t   | out_valid / out_stall
// Bytes are taken one per cycle while the input does not stall; a full block then runs
// a load, 64 rounds of the single round unit and a fold. Finish pads one byte per cycle,
// runs one or two blocks, then presents the digest.
// Synchronous reset restores the initial hash. Input stalls while a block or
// finish runs and while a digest waits to be taken.
module sha256_stream_hasher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha256_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::out_word_t out_data
);
  import sha256_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_word_t digest;
  out_word_t out_reg;

  sha256_control u_ctrl (
    .clk, .rst, .in_valid, .in_command(in_data.command), .in_stall,
    .out_valid, .out_stall, .stat, .cmd
  );

  sha256_datapath u_dp (
    .clk, .rst, .cmd, .message_byte(in_data.message_byte), .stat, .digest
  );

  always_ff @(posedge clk) begin
    if (cmd.restart) out_reg <= digest;
  end

  assign out_data = out_reg;

endmodule

FILE: rtl/sha256_checker.sv
module sha256_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input sha256_pkg::in_word_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input sha256_pkg::out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
  a_stall_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while digest pending");
  a_no_out_on_byte: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !in_data.command |=> !$rose(out_valid))
    else $error("digest after byte");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid) else $error("reset");
endmodule

bind sha256_stream_hasher sha256_checker u_chk (.*);
